// ===== rtl/cylinder_wireframe_vertices_defines.svh =====
// Assertion macros used by the cylinder wireframe vertex RTL.
// Included by cwv_back, which checks its own control logic.
`ifndef CYLINDER_WIREFRAME_VERTICES_DEFINES_SVH
`define CYLINDER_WIREFRAME_VERTICES_DEFINES_SVH
`ifndef SYNTHESIS
`define CWV_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cwv assertion failed");
`define CWV_NEVER(name, cond) \
  `CWV_ASSERT(name, !(cond))
`else
`define CWV_ASSERT(name, prop)
`define CWV_NEVER(name, cond)
`endif
`endif

// ===== rtl/cwv_pkg.sv =====
// Types, constants and trig tables for the cylinder wireframe vertex block.
// No dependencies.
package cwv_pkg;

  localparam int LINES  = 32;
  localparam int LINE_W = $clog2(LINES);

  localparam logic signed [31:0] UP_LIMIT    = 32'sd1072668082;
  localparam longint             CORDIC_GAIN = 64'sd652032874;

  localparam longint ATAN_TURNS [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1
  };

  typedef logic signed [31:0] q30_t;
  typedef q30_t trig_tab_t [LINES];

  typedef struct packed {
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [23:0] sz;
    logic signed [23:0] ex;
    logic signed [23:0] ey;
    logic signed [23:0] ez;
    logic [22:0]        radius;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [15:0]        alpha;
  } req_t;

  typedef struct packed {
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [23:0] sz;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [24:0] dz;
    logic [22:0]        radius;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [15:0]        alpha;
  } seg_t;

  typedef struct packed {
    seg_t seg;
    q30_t rx;
    q30_t ry;
    q30_t rz;
    q30_t vx;
    q30_t vy;
    q30_t vz;
  } frame_t;

  function automatic trig_tab_t cordic_tab(input logic want_sin);
    trig_tab_t tab;
    longint    z;
    longint    x;
    longint    y;
    longint    xs;
    longint    ys;
    logic      neg;
    for (int k = 0; k < LINES; k++) begin
      z = (longint'(k) <<< 32) / LINES;
      if (z >= 64'sh8000_0000) z = z - 64'sh1_0000_0000;
      neg = 1'b0;
      x   = CORDIC_GAIN;
      y   = 0;
      if (z > (64'sd1 <<< 30)) begin
        z   = z - (64'sd1 <<< 31);
        neg = 1'b1;
      end else if (z < -(64'sd1 <<< 30)) begin
        z   = z + (64'sd1 <<< 31);
        neg = 1'b1;
      end
      for (int i = 0; i < 30; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_TURNS[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_TURNS[i];
        end
      end
      if (want_sin) tab[k] = q30_t'(neg ? -y : y);
      else          tab[k] = q30_t'(neg ? -x : x);
    end
    return tab;
  endfunction

  localparam trig_tab_t COS_TAB = cordic_tab(1'b0);
  localparam trig_tab_t SIN_TAB = cordic_tab(1'b1);

endpackage

// ===== rtl/cwv_front.sv =====
// Frame unit: takes requests, forms segment vector and orthonormal frame.
// Shared bit-serial square root and three-lane restoring divider. Uses cwv_pkg.
module cwv_front import cwv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  req_t   req_i,
  output logic   push_o,
  output frame_t frame_o,
  input  logic   q_full_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LEN, ST_SQ1, ST_D1I, ST_D1, ST_U, ST_CROSS, ST_CSQ,
    ST_SQ2, ST_D2I, ST_D2, ST_RIGHT, ST_UP1, ST_UP2, ST_PUSH
  } state_e;

  state_e state_q;
  logic   inb_v_q;
  req_t   inb_q;
  seg_t   seg_q;
  logic [63:0] sq_x_q, sq_r_q, sq_bit_q;
  logic [4:0]  cnt_q;
  logic [31:0] dv_den_q;
  logic [31:0] dv_rem_q [3];
  logic [30:0] dv_lo_q  [3];
  logic [30:0] dv_quo_q [3];
  logic        dv_neg_q [3];
  q30_t u_q [3];
  q30_t c_q [3];
  q30_t r_q [3];
  q30_t v_q [3];
  logic signed [63:0] prod_q [6];

  logic [63:0] sq_sum, sq_x_nx, sq_r_nx;
  logic        sq_ge;
  logic [32:0] dv_t      [3];
  logic        dv_ge     [3];
  logic [31:0] dv_rem_nx [3];
  logic signed [24:0] d_a [3];
  logic signed [49:0] ex, ey, ez;
  logic [49:0] len2;
  logic signed [63:0] csq;

  always_comb begin
    sq_sum  = sq_r_q + sq_bit_q;
    sq_ge   = (sq_x_q >= sq_sum);
    sq_x_nx = sq_ge ? (sq_x_q - sq_sum) : sq_x_q;
    sq_r_nx = sq_ge ? ((sq_r_q >> 1) + sq_bit_q) : (sq_r_q >> 1);
    for (int i = 0; i < 3; i++) begin
      dv_t[i]      = {dv_rem_q[i], dv_lo_q[i][30]};
      dv_ge[i]     = (dv_t[i] >= {1'b0, dv_den_q});
      dv_rem_nx[i] = dv_ge[i] ? 32'(dv_t[i] - {1'b0, dv_den_q}) : dv_t[i][31:0];
    end
    d_a[0] = seg_q.dx;
    d_a[1] = seg_q.dy;
    d_a[2] = seg_q.dz;
    ex     = 50'(seg_q.dx);
    ey     = 50'(seg_q.dy);
    ez     = 50'(seg_q.dz);
    len2   = 50'(ex * ex + ey * ey + ez * ez);
    csq    = 64'(c_q[0]) * 64'(c_q[0]) + 64'(c_q[1]) * 64'(c_q[1])
           + 64'(c_q[2]) * 64'(c_q[2]);
  end

  assign in_ready_o = !inb_v_q;
  assign push_o     = (state_q == ST_PUSH) && !q_full_i;
  assign frame_o    = '{seg: seg_q, rx: r_q[0], ry: r_q[1], rz: r_q[2],
                        vx: v_q[0], vy: v_q[1], vz: v_q[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      inb_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (in_valid_i && !inb_v_q) begin
        inb_v_q <= 1'b1;
        inb_q   <= req_i;
      end else if (state_q == ST_IDLE && inb_v_q) begin
        inb_v_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (inb_v_q) begin
            seg_q.sx     <= inb_q.sx;
            seg_q.sy     <= inb_q.sy;
            seg_q.sz     <= inb_q.sz;
            seg_q.dx     <= {inb_q.ex[23], inb_q.ex} - {inb_q.sx[23], inb_q.sx};
            seg_q.dy     <= {inb_q.ey[23], inb_q.ey} - {inb_q.sy[23], inb_q.sy};
            seg_q.dz     <= {inb_q.ez[23], inb_q.ez} - {inb_q.sz[23], inb_q.sz};
            seg_q.radius <= inb_q.radius;
            seg_q.red    <= inb_q.red;
            seg_q.green  <= inb_q.green;
            seg_q.blue   <= inb_q.blue;
            seg_q.alpha  <= inb_q.alpha;
            for (int i = 0; i < 3; i++) begin
              r_q[i] <= '0;
              v_q[i] <= '0;
            end
            state_q <= ST_LEN;
          end
        end
        ST_LEN: begin
          if (len2 == '0) begin
            state_q <= ST_PUSH;
          end else begin
            sq_x_q   <= {2'b00, len2, 12'h000};
            sq_r_q   <= '0;
            sq_bit_q <= 64'h4000_0000_0000_0000;
            cnt_q    <= '0;
            state_q  <= ST_SQ1;
          end
        end
        ST_SQ1, ST_SQ2: begin
          sq_x_q   <= sq_x_nx;
          sq_r_q   <= sq_r_nx;
          sq_bit_q <= sq_bit_q >> 2;
          cnt_q    <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) state_q <= (state_q == ST_SQ1) ? ST_D1I : ST_D2I;
        end
        ST_D1I: begin
          dv_den_q <= sq_r_q[31:0];
          for (int i = 0; i < 3; i++) begin
            logic [24:0] mag;
            logic [60:0] num;
            mag = d_a[i][24] ? 25'(-d_a[i]) : 25'(d_a[i]);
            num = {mag, 36'h0};
            dv_rem_q[i] <= {2'b00, num[60:31]};
            dv_lo_q[i]  <= num[30:0];
            dv_quo_q[i] <= '0;
            dv_neg_q[i] <= d_a[i][24];
          end
          cnt_q   <= '0;
          state_q <= ST_D1;
        end
        ST_D1, ST_D2: begin
          for (int i = 0; i < 3; i++) begin
            dv_rem_q[i] <= dv_rem_nx[i];
            dv_lo_q[i]  <= {dv_lo_q[i][29:0], 1'b0};
            dv_quo_q[i] <= {dv_quo_q[i][29:0], dv_ge[i]};
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd30) state_q <= (state_q == ST_D1) ? ST_U : ST_RIGHT;
        end
        ST_U: begin
          for (int i = 0; i < 3; i++)
            u_q[i] <= dv_neg_q[i] ? -$signed({1'b0, dv_quo_q[i]})
                                  : $signed({1'b0, dv_quo_q[i]});
          state_q <= ST_CROSS;
        end
        ST_CROSS: begin
          if (u_q[1] > UP_LIMIT) begin
            c_q[0] <= u_q[1];
            c_q[1] <= -u_q[0];
            c_q[2] <= '0;
          end else if (u_q[1] < -UP_LIMIT) begin
            c_q[0] <= -u_q[1];
            c_q[1] <= u_q[0];
            c_q[2] <= '0;
          end else begin
            c_q[0] <= -u_q[2];
            c_q[1] <= '0;
            c_q[2] <= u_q[0];
          end
          state_q <= ST_CSQ;
        end
        ST_CSQ: begin
          sq_x_q   <= csq;
          sq_r_q   <= '0;
          sq_bit_q <= 64'h4000_0000_0000_0000;
          cnt_q    <= '0;
          state_q  <= ST_SQ2;
        end
        ST_D2I: begin
          if (sq_r_q == '0) begin
            state_q <= ST_PUSH;
          end else begin
            dv_den_q <= sq_r_q[31:0];
            for (int i = 0; i < 3; i++) begin
              logic [30:0] magc;
              logic [60:0] numc;
              magc = c_q[i][31] ? 31'(-c_q[i]) : 31'(c_q[i]);
              numc = {magc, 30'h0};
              dv_rem_q[i] <= {2'b00, numc[60:31]};
              dv_lo_q[i]  <= numc[30:0];
              dv_quo_q[i] <= '0;
              dv_neg_q[i] <= c_q[i][31];
            end
            cnt_q   <= '0;
            state_q <= ST_D2;
          end
        end
        ST_RIGHT: begin
          for (int i = 0; i < 3; i++)
            r_q[i] <= dv_neg_q[i] ? -$signed({1'b0, dv_quo_q[i]})
                                  : $signed({1'b0, dv_quo_q[i]});
          state_q <= ST_UP1;
        end
        ST_UP1: begin
          prod_q[0] <= 64'(r_q[1]) * 64'(u_q[2]);
          prod_q[1] <= 64'(r_q[2]) * 64'(u_q[1]);
          prod_q[2] <= 64'(r_q[2]) * 64'(u_q[0]);
          prod_q[3] <= 64'(r_q[0]) * 64'(u_q[2]);
          prod_q[4] <= 64'(r_q[0]) * 64'(u_q[1]);
          prod_q[5] <= 64'(r_q[1]) * 64'(u_q[0]);
          state_q   <= ST_UP2;
        end
        ST_UP2: begin
          v_q[0]  <= 32'((prod_q[0] - prod_q[1]) >>> 30);
          v_q[1]  <= 32'((prod_q[2] - prod_q[3]) >>> 30);
          v_q[2]  <= 32'((prod_q[4] - prod_q[5]) >>> 30);
          state_q <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!q_full_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/cwv_queue.sv =====
// Two-entry frame queue between the frame unit and the vertex pipeline.
// Uses cwv_pkg.
module cwv_queue import cwv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t frame_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output frame_t frame_o
);

  frame_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign frame_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= frame_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/cwv_back.sv =====
// Vertex pipeline: per line rotates the frame, scales by radius, emits
// base and far vertices. Uses cwv_pkg and the assertion macros.
`include "cylinder_wireframe_vertices_defines.svh"
module cwv_back import cwv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  frame_t             frame_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] vertex_x_o,
  output logic signed [23:0] vertex_y_o,
  output logic signed [23:0] vertex_z_o,
  output logic [15:0]        out_red_o,
  output logic [15:0]        out_green_o,
  output logic [15:0]        out_blue_o,
  output logic [15:0]        out_alpha_o,
  output logic               far_end_o,
  output logic               last_vertex_o
);

  typedef struct packed {
    seg_t seg;
    logic last;
  } line_t;

  logic [LINE_W-1:0]  k_q;
  logic               v1_q, v2_q, v3_q, v4_q, ph_q, ov_q;
  line_t              ln1_q, ln2_q, ln3_q, ln4_q;
  logic signed [63:0] cr_q [3];
  logic signed [63:0] sv_q [3];
  logic signed [33:0] w_q  [3];
  logic signed [63:0] p_q  [3];
  logic signed [27:0] base_q [3];
  logic signed [23:0] vx_q, vy_q, vz_q;
  logic [15:0]        red_q, green_q, blue_q, alpha_q;
  logic               far_q, last_q;

  logic adv, issue, oload, k_last;
  q30_t fr_r [3];
  q30_t fr_v [3];
  logic signed [23:0] s_a [3];
  logic signed [24:0] d_a [3];
  logic signed [23:0] vo  [3];

  function automatic logic signed [23:0] sat24(input logic signed [28:0] v);
    if (v > 29'sd8388607)        return 24'sh7FFFFF;
    else if (v < -29'sd8388608)  return 24'sh800000;
    else                         return 24'(v);
  endfunction

  always_comb begin
    oload  = v4_q && (!ov_q || out_ready_i);
    adv    = !v4_q || (ph_q && oload);
    issue  = q_valid_i && adv;
    k_last = (k_q == LINE_W'(LINES - 1));
    fr_r[0] = frame_i.rx;
    fr_r[1] = frame_i.ry;
    fr_r[2] = frame_i.rz;
    fr_v[0] = frame_i.vx;
    fr_v[1] = frame_i.vy;
    fr_v[2] = frame_i.vz;
    s_a[0]  = ln3_q.seg.sx;
    s_a[1]  = ln3_q.seg.sy;
    s_a[2]  = ln3_q.seg.sz;
    d_a[0]  = ln4_q.seg.dx;
    d_a[1]  = ln4_q.seg.dy;
    d_a[2]  = ln4_q.seg.dz;
    for (int i = 0; i < 3; i++)
      vo[i] = ph_q ? sat24(29'(base_q[i]) + 29'(d_a[i])) : sat24(29'(base_q[i]));
  end

  assign pop_o         = issue && k_last;
  assign out_valid_o   = ov_q;
  assign vertex_x_o    = vx_q;
  assign vertex_y_o    = vy_q;
  assign vertex_z_o    = vz_q;
  assign out_red_o     = red_q;
  assign out_green_o   = green_q;
  assign out_blue_o    = blue_q;
  assign out_alpha_o   = alpha_q;
  assign far_end_o     = far_q;
  assign last_vertex_o = last_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ln1_q <= '{seg: frame_i.seg, last: k_last};
      for (int i = 0; i < 3; i++) begin
        cr_q[i] <= 64'(COS_TAB[k_q]) * 64'(fr_r[i]);
        sv_q[i] <= 64'(SIN_TAB[k_q]) * 64'(fr_v[i]);
      end
      ln2_q <= ln1_q;
      for (int i = 0; i < 3; i++) w_q[i] <= 34'((cr_q[i] + sv_q[i]) >>> 30);
      ln3_q <= ln2_q;
      for (int i = 0; i < 3; i++)
        p_q[i] <= 64'($signed({1'b0, ln2_q.seg.radius})) * 64'(w_q[i])
                + (64'sd1 <<< 29);
      ln4_q <= ln3_q;
      for (int i = 0; i < 3; i++)
        base_q[i] <= 28'(s_a[i]) + 28'(p_q[i] >>> 30);
    end
    if (oload) begin
      vx_q    <= vo[0];
      vy_q    <= vo[1];
      vz_q    <= vo[2];
      red_q   <= ln4_q.seg.red;
      green_q <= ln4_q.seg.green;
      blue_q  <= ln4_q.seg.blue;
      alpha_q <= ln4_q.seg.alpha;
      far_q   <= ph_q;
      last_q  <= ph_q && ln4_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ph_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (issue) k_q <= k_last ? '0 : k_q + LINE_W'(1);
      if (adv) begin
        v1_q <= issue;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
      end
      if (oload) ph_q <= !ph_q;
      if (oload)            ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  `CWV_NEVER(a_pop_needs_item, pop_o && !q_valid_i)
  `CWV_ASSERT(a_last_is_far, (out_valid_o && last_vertex_o) |-> far_end_o)
  `CWV_ASSERT(a_base_then_far, (oload && !ph_q) |=> (v4_q && ph_q))

endmodule

// ===== rtl/cylinder_wireframe_vertices.sv =====
// Cylinder wireframe vertex generator. Each request (segment start, end,
// radius, color) yields 2*LINES vertices: for each of LINES lines around the
// tube, a base vertex on the circle about the start point, then that vertex
// moved by the segment vector; last_vertex_o marks the final one. The frame
// unit computes each frame with two 32-step square roots and two 31-step
// divisions, one bit per cycle, and skips them for a zero-length segment;
// the vertex pipeline emits one vertex per cycle while frames are queued and
// out_ready_i does not stall it, with a two-entry frame queue between them.
// Sustained request throughput is set by the frame unit's iterations.
module cylinder_wireframe_vertices import cwv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] start_x_i,
  input  logic signed [23:0] start_y_i,
  input  logic signed [23:0] start_z_i,
  input  logic signed [23:0] end_x_i,
  input  logic signed [23:0] end_y_i,
  input  logic signed [23:0] end_z_i,
  input  logic [22:0]        radius_i,
  input  logic [15:0]        color_red_i,
  input  logic [15:0]        color_green_i,
  input  logic [15:0]        color_blue_i,
  input  logic [15:0]        color_alpha_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] vertex_x_o,
  output logic signed [23:0] vertex_y_o,
  output logic signed [23:0] vertex_z_o,
  output logic [15:0]        out_red_o,
  output logic [15:0]        out_green_o,
  output logic [15:0]        out_blue_o,
  output logic [15:0]        out_alpha_o,
  output logic               far_end_o,
  output logic               last_vertex_o
);

  req_t   req;
  frame_t push_frame, head_frame;
  logic   push, q_full, q_valid, pop;

  assign req = '{sx: start_x_i, sy: start_y_i, sz: start_z_i,
                 ex: end_x_i, ey: end_y_i, ez: end_z_i, radius: radius_i,
                 red: color_red_i, green: color_green_i,
                 blue: color_blue_i, alpha: color_alpha_i};

  cwv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_i      (req),
    .push_o     (push),
    .frame_o    (push_frame),
    .q_full_i   (q_full)
  );

  cwv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (push_frame),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .frame_o (head_frame)
  );

  cwv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .frame_i       (head_frame),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .vertex_x_o    (vertex_x_o),
    .vertex_y_o    (vertex_y_o),
    .vertex_z_o    (vertex_z_o),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .out_alpha_o   (out_alpha_o),
    .far_end_o     (far_end_o),
    .last_vertex_o (last_vertex_o)
  );

endmodule

// ===== test/tb_cylinder_wireframe_vertices.sv =====
// Self-checking testbench for cylinder_wireframe_vertices. Runs a directed
// table and random segments and checks every vertex against a fixed point
// tube predictor or preset start/end points. Depends on cwv_pkg and the RTL.
`timescale 1ns / 1ps

module tb_cylinder_wireframe_vertices;
  import cwv_pkg::*;

  localparam int     N_RANDOM    = 170;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam longint ONE30       = 64'sd1 <<< 30;

  typedef enum int {CHECK_MODEL, AT_START, BASE_START_FAR_END} row_kind_e;

  typedef struct {
    req_t      req;
    row_kind_e kind;
  } table_row_t;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [15:0]        alpha;
    logic               far_end;
    logic               last_vertex;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [23:0] start_x_i = '0, start_y_i = '0, start_z_i = '0;
  logic signed [23:0] end_x_i = '0, end_y_i = '0, end_z_i = '0;
  logic [22:0] radius_i = '0;
  logic [15:0] color_red_i = '0, color_green_i = '0, color_blue_i = '0, color_alpha_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [23:0] vertex_x_o, vertex_y_o, vertex_z_o;
  logic [15:0] out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic far_end_o, last_vertex_o;

  vertex_t    expected_vertices[$];
  table_row_t directed_rows[$];
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         errors = 0;
  int         requests_sent = 0;
  int         vertices_checked = 0;
  longint     cycles = 0;

  cylinder_wireframe_vertices dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  task automatic rotate_phase(input int k, output longint cos_q30, output longint sin_q30);
    longint ang;
    longint cx;
    longint cy;
    longint tx;
    logic   flip;
    ang = (longint'(k) <<< 32) / LINES;
    if (ang >= 64'sh8000_0000) ang = ang - 64'sh1_0000_0000;
    flip = 1'b0;
    if (ang > ONE30) begin
      ang = ang - (ONE30 <<< 1);
      flip = 1'b1;
    end else if (ang < -ONE30) begin
      ang = ang + (ONE30 <<< 1);
      flip = 1'b1;
    end
    cx = CORDIC_GAIN;
    cy = 0;
    for (int i = 0; i < 30; i++) begin
      tx = cx;
      if (ang >= 0) begin
        cx = cx - (cy >>> i);
        cy = cy + (tx >>> i);
        ang = ang - ATAN_TURNS[i];
      end else begin
        cx = cx + (cy >>> i);
        cy = cy - (tx >>> i);
        ang = ang + ATAN_TURNS[i];
      end
    end
    cos_q30 = flip ? -cx : cx;
    sin_q30 = flip ? -cy : cy;
  endtask

  task automatic push_vertex(input req_t q, input longint x, input longint y, input longint z,
                             input logic far_end, input logic last_vertex);
    vertex_t v;
    v.x = clamp24(x);
    v.y = clamp24(y);
    v.z = clamp24(z);
    v.red = q.red;
    v.green = q.green;
    v.blue = q.blue;
    v.alpha = q.alpha;
    v.far_end = far_end;
    v.last_vertex = last_vertex;
    expected_vertices = {expected_vertices, v};
  endtask

  task automatic add_row(input req_t q, input row_kind_e kind);
    table_row_t r;
    r.req = q;
    r.kind = kind;
    directed_rows = {directed_rows, r};
  endtask

  task automatic predict_tube(input req_t q);
    longint sx, sy, sz, dx, dy, dz, rad, len2, len6;
    longint ux, uy, uz, cx, cy, cz, rl;
    longint rx, ry, rz, vx, vy, vz;
    longint co, si, wx, wy, wz, bx, by, bz;
    sx = q.sx; sy = q.sy; sz = q.sz;
    dx = longint'(q.ex) - sx;
    dy = longint'(q.ey) - sy;
    dz = longint'(q.ez) - sz;
    rad = longint'({1'b0, q.radius});
    len2 = dx * dx + dy * dy + dz * dz;
    rx = 0; ry = 0; rz = 0; vx = 0; vy = 0; vz = 0;
    if (len2 != 0) begin
      len6 = longint'(root64(longint'(len2) << 12));
      ux = (dx <<< 36) / len6;
      uy = (dy <<< 36) / len6;
      uz = (dz <<< 36) / len6;
      if (uy > longint'(UP_LIMIT)) begin
        cx = uy; cy = -ux; cz = 0;
      end else if (uy < -longint'(UP_LIMIT)) begin
        cx = -uy; cy = ux; cz = 0;
      end else begin
        cx = -uz; cy = 0; cz = ux;
      end
      rl = longint'(root64(cx * cx + cy * cy + cz * cz));
      if (rl != 0) begin
        rx = (cx <<< 30) / rl;
        ry = (cy <<< 30) / rl;
        rz = (cz <<< 30) / rl;
        vx = (ry * uz - rz * uy) >>> 30;
        vy = (rz * ux - rx * uz) >>> 30;
        vz = (rx * uy - ry * ux) >>> 30;
      end
    end
    for (int k = 0; k < LINES; k++) begin
      rotate_phase(k, co, si);
      wx = (co * rx + si * vx) >>> 30;
      wy = (co * ry + si * vy) >>> 30;
      wz = (co * rz + si * vz) >>> 30;
      bx = sx + ((rad * wx + (ONE30 >>> 1)) >>> 30);
      by = sy + ((rad * wy + (ONE30 >>> 1)) >>> 30);
      bz = sz + ((rad * wz + (ONE30 >>> 1)) >>> 30);
      push_vertex(q, bx, by, bz, 1'b0, 1'b0);
      push_vertex(q, bx + dx, by + dy, bz + dz, 1'b1, k == LINES - 1);
    end
  endtask

  task automatic send_request(input req_t q, input row_kind_e kind);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    {start_x_i, start_y_i, start_z_i} = {q.sx, q.sy, q.sz};
    {end_x_i, end_y_i, end_z_i} = {q.ex, q.ey, q.ez};
    radius_i = q.radius;
    {color_red_i, color_green_i, color_blue_i, color_alpha_i} = {q.red, q.green, q.blue, q.alpha};
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    case (kind)
      AT_START: begin
        for (int k = 0; k < 2 * LINES; k++)
          push_vertex(q, q.sx, q.sy, q.sz, k[0], k == 2 * LINES - 1);
      end
      BASE_START_FAR_END: begin
        for (int k = 0; k < 2 * LINES; k++) begin
          if (k[0]) push_vertex(q, q.ex, q.ey, q.ez, 1'b1, k == 2 * LINES - 1);
          else      push_vertex(q, q.sx, q.sy, q.sz, 1'b0, 1'b0);
        end
      end
      default: predict_tube(q);
    endcase
    requests_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic req_t make_req(longint sx, longint sy, longint sz, longint ex, longint ey,
                                    longint ez, longint rad, logic [63:0] rgba);
    req_t q;
    q.sx = sx[23:0]; q.sy = sy[23:0]; q.sz = sz[23:0];
    q.ex = ex[23:0]; q.ey = ey[23:0]; q.ez = ez[23:0];
    q.radius = rad[22:0];
    {q.red, q.green, q.blue, q.alpha} = rgba;
    return q;
  endfunction

  function automatic req_t random_req();
    req_t q;
    int   shape;
    shape = $urandom_range(9);
    q = make_req(0, 0, 0, 0, 0, 0, 0, {$urandom, $urandom});
    q.sx = 24'($urandom); q.sy = 24'($urandom); q.sz = 24'($urandom);
    q.radius = 23'($urandom);
    if (shape < 5) begin
      q.sx = $signed(q.sx) >>> 4; q.sy = $signed(q.sy) >>> 4; q.sz = $signed(q.sz) >>> 4;
      q.ex = q.sx + ($signed(24'($urandom)) >>> 5);
      q.ey = q.sy + ($signed(24'($urandom)) >>> 5);
      q.ez = q.sz + ($signed(24'($urandom)) >>> 5);
      q.radius = q.radius >> $urandom_range(8, 2);
    end else if (shape < 7) begin
      q.ex = 24'($urandom); q.ey = 24'($urandom); q.ez = 24'($urandom);
    end else if (shape < 8) begin
      q.ex = q.sx + $signed(24'($urandom_range(3))) - 24'sd1;
      q.ey = q.sy + ($signed(24'($urandom)) >>> 2);
      q.ez = q.sz + $signed(24'($urandom_range(3))) - 24'sd1;
    end else if (shape < 9) begin
      q.ex = q.sx + $signed(24'($urandom_range(2))) - 24'sd1;
      q.ey = q.sy + $signed(24'($urandom_range(2))) - 24'sd1;
      q.ez = q.sz + $signed(24'($urandom_range(2))) - 24'sd1;
    end else begin
      q.ex = q.sx; q.ey = q.sy; q.ez = q.sz;
    end
    return q;
  endfunction

  always @(negedge clk_i) out_ready_i <= rst_ni && ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    vertex_t v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_vertices.size() == 0) begin
        $error("vertex with no request pending");
        errors++;
      end else begin
        v = expected_vertices.pop_front();
        vertices_checked++;
        if (vertex_x_o !== v.x) begin
          $error("vertex_x expected %0d got %0d", v.x, vertex_x_o); errors++;
        end
        if (vertex_y_o !== v.y) begin
          $error("vertex_y expected %0d got %0d", v.y, vertex_y_o); errors++;
        end
        if (vertex_z_o !== v.z) begin
          $error("vertex_z expected %0d got %0d", v.z, vertex_z_o); errors++;
        end
        if (out_red_o !== v.red) begin
          $error("out_red expected %0h got %0h", v.red, out_red_o); errors++;
        end
        if (out_green_o !== v.green) begin
          $error("out_green expected %0h got %0h", v.green, out_green_o); errors++;
        end
        if (out_blue_o !== v.blue) begin
          $error("out_blue expected %0h got %0h", v.blue, out_blue_o); errors++;
        end
        if (out_alpha_o !== v.alpha) begin
          $error("out_alpha expected %0h got %0h", v.alpha, out_alpha_o); errors++;
        end
        if (far_end_o !== v.far_end) begin
          $error("far_end expected %0b got %0b", v.far_end, far_end_o); errors++;
        end
        if (last_vertex_o !== v.last_vertex) begin
          $error("last_vertex expected %0b got %0b", v.last_vertex, last_vertex_o); errors++;
        end
      end
    end
  end

  initial begin
    add_row(make_req(0, 0, 0, 0, 0, 0, 8388607, 64'hFFFF_0000_FFFF_0000), AT_START);
    add_row(make_req(-8388608, 8388607, -8388608, -8388608, 8388607, -8388608,
                     4096, 64'h0000_FFFF_0000_FFFF), AT_START);
    add_row(make_req(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                     0, 64'hFFFF_FFFF_FFFF_FFFF), BASE_START_FAR_END);
    add_row(make_req(100, -200, 300, 5000, 7000, -9000, 0, 64'h1234_5678_9ABC_DEF0),
            BASE_START_FAR_END);
    add_row(make_req(0, 0, 0, 65536, 0, 0, 65536, 64'h0), CHECK_MODEL);
    add_row(make_req(0, 0, 0, 0, 65536, 0, 65536, 64'h1111), CHECK_MODEL);
    add_row(make_req(0, 0, 0, 0, -65536, 0, 65536, 64'h2222), CHECK_MODEL);
    add_row(make_req(0, 0, 0, 0, 0, 65536, 131072, 64'h3333), CHECK_MODEL);
    add_row(make_req(0, 0, 0, 1, 1, 0, 65536, 64'h4444), CHECK_MODEL);
    add_row(make_req(0, 0, 0, 2900, 65536, 0, 65536, 64'h5555), CHECK_MODEL);
    add_row(make_req(0, 0, 0, 2950, -65536, 1, 65536, 64'h6666), CHECK_MODEL);
    add_row(make_req(8388607, 8388607, 8388607, 8388000, 8388600, 8388500,
                     8388607, 64'hAAAA_5555_AAAA_5555), CHECK_MODEL);
    add_row(make_req(-8388608, -8388608, -8388608, -8388000, -8388600, -8388500,
                     8388607, 64'h5555_AAAA_5555_AAAA), CHECK_MODEL);
    add_row(make_req(-8388608, 8388607, 0, 8388607, -8388608, 1, 8388607,
                     64'h8000_7FFF_0001_FFFE), CHECK_MODEL);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed_rows[i]) send_request(directed_rows[i].req, directed_rows[i].kind);
    for (int n = 0; n < N_RANDOM; n++) begin
      case (n * 4 / N_RANDOM)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 73; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 73; end
        default: begin gap_pct = 8; stall_pct = 8; end
      endcase
      send_request(random_req(), CHECK_MODEL);
    end
    wait (expected_vertices.size() == 0);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d segment requests, checked %0d vertices.", requests_sent, vertices_checked);
    $display("Covered zero-length, zero-radius, vertical and saturating segments.");
    if (errors == 0 && expected_vertices.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cwv_pkg.sv
rtl/cwv_front.sv
rtl/cwv_queue.sv
rtl/cwv_back.sv
rtl/cylinder_wireframe_vertices.sv
test/tb_cylinder_wireframe_vertices.sv
